FILE: rtl/ipmc_pkg.sv
`timescale 1ns / 1ps

package ipmc_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TIMER_W    = 32;
    localparam int unsigned LOAD_W     = 7;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET   = '1;
    localparam logic [LOAD_W-1:0]  CPU_LIMIT_RESET = LOAD_W'(5);

    typedef enum logic [1:0] {
        REG_BLANK_TIMEOUT = 2'd0,
        REG_SLEEP_TIMEOUT = 2'd1,
        REG_CHECK_CPU     = 2'd2,
        REG_CPU_LIMIT     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DIM    = 2'd1,
        MODE_BLANK  = 2'd2,
        MODE_SLEEP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ACTIVITY = 2'd1,
        CMD_ALARM    = 2'd2,
        CMD_SESSION  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              sess_idle;
        logic              idle_blocked;
        logic              susp_blocked;
        logic [LOAD_W-1:0] cpu_load;
    } t_in_item;

    typedef struct packed {
        logic [1:0] power_mode;
        logic       mode_changed;
    } t_out_item;

endpackage

FILE: rtl/ipmc_stream_if.sv
`timescale 1ns / 1ps

interface ipmc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/idle_power_mode_controller.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                             Handshake
// i_evt     in   cmd, sess_idle, idle_blocked,                       valid/ready
//                susp_blocked, cpu_load
// o_res     out  power_mode, mode_changed                            valid/ready
// APB       in   4 registers at byte addresses 0, 4, 8, 12           psel/penable
//
// Each event word is registered on entry and processed once the result register is free,
// when the timers and mode are updated and the result word is registered.
// o_res.valid comes from the result register; one word per cycle while o_res is not stalled.
// The result register lets a new event enter while a result waits; the entry
// register holds when the result side stalls.
// Reset (i_rst_n, synchronous) returns normal mode, both timers disarmed and
// the registers to their reset values.

module idle_power_mode_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ipmc_stream_if.sink                        i_evt,
    ipmc_stream_if.source                      o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ipmc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [ipmc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [ipmc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    typedef ipmc_pkg::t_reg_idx t_reg_sel;

    // Configuration registers
    logic [ipmc_pkg::TIMER_W-1:0] r_blank_timeout;
    logic [ipmc_pkg::TIMER_W-1:0] r_sleep_timeout;
    logic                         r_check_cpu;
    logic [ipmc_pkg::LOAD_W-1:0]  r_cpu_limit;

    // Controller state
    ipmc_pkg::t_mode              r_mode, n_mode;
    logic                         r_user_idle, n_user_idle;
    logic                         r_blank_armed, n_blank_armed;
    logic                         r_blank_running, n_blank_running;
    logic [ipmc_pkg::TIMER_W-1:0] r_blank_rem, n_blank_rem;
    logic                         r_sleep_armed, n_sleep_armed;
    logic                         r_sleep_running, n_sleep_running;
    logic [ipmc_pkg::TIMER_W-1:0] r_sleep_rem, n_sleep_rem;

    // Entry and result registers
    logic                         r_in_valid;
    ipmc_pkg::t_in_item           r_in;
    logic                         r_out_valid;
    ipmc_pkg::t_out_item          r_out;

    logic                         w_out_free;
    logic                         w_proc;
    logic                         w_wr;
    t_reg_sel                     w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_sel  = ipmc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_timeout <= ipmc_pkg::TIMEOUT_RESET;
            r_sleep_timeout <= ipmc_pkg::TIMEOUT_RESET;
            r_check_cpu     <= 1'b0;
            r_cpu_limit     <= ipmc_pkg::CPU_LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_sel)
                ipmc_pkg::REG_BLANK_TIMEOUT: r_blank_timeout <= pwdata;
                ipmc_pkg::REG_SLEEP_TIMEOUT: r_sleep_timeout <= pwdata;
                ipmc_pkg::REG_CHECK_CPU:     r_check_cpu     <= pwdata[0];
                ipmc_pkg::REG_CPU_LIMIT:     r_cpu_limit     <= pwdata[ipmc_pkg::LOAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            ipmc_pkg::REG_BLANK_TIMEOUT: prdata = r_blank_timeout;
            ipmc_pkg::REG_SLEEP_TIMEOUT: prdata = r_sleep_timeout;
            ipmc_pkg::REG_CHECK_CPU:
                prdata = {{(ipmc_pkg::CFG_DATA_W-1){1'b0}}, r_check_cpu};
            ipmc_pkg::REG_CPU_LIMIT:
                prdata = {{(ipmc_pkg::CFG_DATA_W-ipmc_pkg::LOAD_W){1'b0}}, r_cpu_limit};
            default: prdata = '0;
        endcase
    end

    // Handshake and pipeline advance
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_proc      = r_in_valid && w_out_free;
    assign i_evt.ready = !r_in_valid || w_out_free;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in <= i_evt.data;
        end
    end

    // One event step
    always_comb begin
        n_mode          = r_mode;
        n_user_idle     = r_user_idle;
        n_blank_armed   = r_blank_armed;
        n_blank_running = r_blank_running;
        n_blank_rem     = r_blank_rem;
        n_sleep_armed   = r_sleep_armed;
        n_sleep_running = r_sleep_running;
        n_sleep_rem     = r_sleep_rem;

        case (ipmc_pkg::t_cmd'(r_in.cmd))
            ipmc_pkg::CMD_TICK: begin
                if (r_blank_running) begin
                    if (r_blank_rem <= ipmc_pkg::TIMER_W'(1)) begin
                        n_blank_running = 1'b0;
                        n_blank_rem     = '0;
                        if (r_mode != ipmc_pkg::MODE_SLEEP) begin
                            n_mode = ipmc_pkg::MODE_BLANK;
                        end
                    end else begin
                        n_blank_rem = r_blank_rem - ipmc_pkg::TIMER_W'(1);
                    end
                end
                if (r_sleep_running) begin
                    if (r_sleep_rem <= ipmc_pkg::TIMER_W'(1)) begin
                        // With cpu checking on, a busy cpu pushes sleep back by one full interval.
                        if (r_check_cpu && (r_in.cpu_load > r_cpu_limit)) begin
                            n_sleep_rem = r_sleep_timeout;
                        end else begin
                            n_sleep_running = 1'b0;
                            n_sleep_rem     = '0;
                            n_mode          = ipmc_pkg::MODE_SLEEP;
                        end
                    end else begin
                        n_sleep_rem = r_sleep_rem - ipmc_pkg::TIMER_W'(1);
                    end
                end
            end
            default: begin
                if (r_in.cmd == ipmc_pkg::CMD_ACTIVITY) begin
                    n_user_idle = 1'b0;
                end else if (r_in.cmd == ipmc_pkg::CMD_ALARM) begin
                    n_user_idle = 1'b1;
                end

                if (!n_user_idle || r_in.idle_blocked) begin
                    n_mode          = ipmc_pkg::MODE_NORMAL;
                    n_blank_armed   = 1'b0;
                    n_blank_running = 1'b0;
                    n_blank_rem     = '0;
                    n_sleep_armed   = 1'b0;
                    n_sleep_running = 1'b0;
                    n_sleep_rem     = '0;
                end else begin
                    if (r_mode == ipmc_pkg::MODE_NORMAL) begin
                        n_mode = ipmc_pkg::MODE_DIM;
                    end
                    if (!r_blank_armed && (r_blank_timeout != '0)) begin
                        n_blank_armed   = 1'b1;
                        n_blank_running = 1'b1;
                        n_blank_rem     = r_blank_timeout;
                    end
                    if (r_in.susp_blocked) begin
                        n_sleep_armed   = 1'b0;
                        n_sleep_running = 1'b0;
                        n_sleep_rem     = '0;
                    end else if (r_in.sess_idle) begin
                        if (!r_sleep_armed && (r_sleep_timeout != '0)) begin
                            n_sleep_armed   = 1'b1;
                            n_sleep_running = 1'b1;
                            n_sleep_rem     = r_sleep_timeout;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ipmc_pkg::MODE_NORMAL;
            r_user_idle     <= 1'b0;
            r_blank_armed   <= 1'b0;
            r_blank_running <= 1'b0;
            r_blank_rem     <= '0;
            r_sleep_armed   <= 1'b0;
            r_sleep_running <= 1'b0;
            r_sleep_rem     <= '0;
        end else if (w_proc) begin
            r_mode          <= n_mode;
            r_user_idle     <= n_user_idle;
            r_blank_armed   <= n_blank_armed;
            r_blank_running <= n_blank_running;
            r_blank_rem     <= n_blank_rem;
            r_sleep_armed   <= n_sleep_armed;
            r_sleep_running <= n_sleep_running;
            r_sleep_rem     <= n_sleep_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out.power_mode   <= n_mode;
            r_out.mode_changed <= (n_mode != r_mode);
        end
    end

    // A running timer is always an armed one.
    a_blank_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blank_running |-> r_blank_armed)
        else $error("blank timer running while disarmed");

    a_sleep_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep_running |-> r_sleep_armed)
        else $error("sleep timer running while disarmed");

    // Normal mode only comes with both timers disarmed.
    a_normal_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ipmc_pkg::MODE_NORMAL) |-> (!r_blank_armed && !r_sleep_armed))
        else $error("timer armed in normal mode");

    a_activity_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in.cmd == ipmc_pkg::CMD_ACTIVITY))
            |=> (r_out_valid && (r_out.power_mode == ipmc_pkg::MODE_NORMAL)))
        else $error("activity did not return normal mode");

    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |=> (r_out.mode_changed == (r_mode != $past(r_mode))))
        else $error("mode change flag disagrees with state");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          PLAN_LEN    = 25;
    localparam int          PHASE_ITEMS = 100;

    // One row of the directed plan: either a register write or an event word.
    // Where typed is set, the expected result is the one written in the row.
    typedef struct packed {
        logic                        is_write;
        ipmc_pkg::t_reg_idx          reg_sel;
        logic [31:0]                 value;
        ipmc_pkg::t_cmd              cmd;
        logic                        s_idle;
        logic                        i_inh;
        logic                        s_inh;
        logic [ipmc_pkg::LOAD_W-1:0] load;
        logic                        typed;
        ipmc_pkg::t_mode             mode;
        logic                        chg;
    } t_plan_row;

    typedef struct {
        bit                  typed;
        ipmc_pkg::t_out_item want;
    } t_row_note;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ipmc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ipmc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [ipmc_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    ipmc_stream_if #(.T(ipmc_pkg::t_in_item))  evt_ch ();
    ipmc_stream_if #(.T(ipmc_pkg::t_out_item)) res_ch ();

    idle_power_mode_controller uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state, mirroring the block after reset.
    ipmc_pkg::t_mode cur_mode       = ipmc_pkg::MODE_NORMAL;
    logic            idle_flag      = 1'b0;
    logic            blank_on       = 1'b0;
    logic            blank_counting = 1'b0;
    logic [31:0]     blank_left     = '0;
    logic            sleep_on       = 1'b0;
    logic            sleep_counting = 1'b0;
    logic [31:0]     sleep_left     = '0;

    logic [31:0]                 blank_after = ipmc_pkg::TIMEOUT_RESET;
    logic [31:0]                 sleep_after = ipmc_pkg::TIMEOUT_RESET;
    logic                        cpu_gate    = 1'b0;
    logic [ipmc_pkg::LOAD_W-1:0] busy_limit  = ipmc_pkg::CPU_LIMIT_RESET;

    ipmc_pkg::t_out_item expected_modes [$];
    t_row_note   row_notes [$];
    int unsigned errors   = 0;
    int unsigned checked  = 0;
    int unsigned accepted = 0;
    int unsigned changes  = 0;
    int unsigned mode_hits [4] = '{0, 0, 0, 0};
    int unsigned cycles   = 0;
    bit          calm      = 1'b0;
    bit          stall_req = 1'b0;

    t_plan_row plan [PLAN_LEN] = '{
        // Straight out of reset nothing is idle, so events stay in normal mode until an alarm dims it.
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b1, 1'b1, 1'b1, 7'd127, 1'b1, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ACTIVITY,
          1'b1, 1'b0, 1'b0, 7'd0, 1'b1, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_SESSION,
          1'b1, 1'b0, 1'b0, 7'd64, 1'b1, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ALARM,
          1'b1, 1'b0, 1'b0, 7'd0, 1'b1, ipmc_pkg::MODE_DIM, 1'b1},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b1, ipmc_pkg::MODE_DIM, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ALARM,
          1'b1, 1'b1, 1'b0, 7'd0, 1'b1, ipmc_pkg::MODE_NORMAL, 1'b1},
        '{1'b1, ipmc_pkg::REG_BLANK_TIMEOUT, 32'd2, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b1, ipmc_pkg::REG_SLEEP_TIMEOUT, 32'd1, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b1, ipmc_pkg::REG_CHECK_CPU, 32'd1, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b1, ipmc_pkg::REG_CPU_LIMIT, 32'd100, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        // Sleep comes due while the load is high, so it reloads and retries.
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ALARM,
          1'b1, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd101, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        // A zero sleep timeout makes each retry come due on the very next tick.
        '{1'b1, ipmc_pkg::REG_SLEEP_TIMEOUT, 32'd0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b1, 1'b1, 1'b1, 7'd127, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd127, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd100, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ACTIVITY,
          1'b1, 1'b0, 1'b0, 7'd0, 1'b1, ipmc_pkg::MODE_NORMAL, 1'b1},
        // Sleep fires before blank; the later blank expiry must not leave sleep.
        '{1'b1, ipmc_pkg::REG_BLANK_TIMEOUT, 32'd3, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b1, ipmc_pkg::REG_SLEEP_TIMEOUT, 32'd1, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b1, ipmc_pkg::REG_CHECK_CPU, 32'd0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_ALARM,
          1'b1, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_TICK,
          1'b0, 1'b0, 1'b0, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0},
        '{1'b0, ipmc_pkg::REG_BLANK_TIMEOUT, '0, ipmc_pkg::CMD_SESSION,
          1'b1, 1'b0, 1'b1, 7'd0, 1'b0, ipmc_pkg::MODE_NORMAL, 1'b0}
    };

    function automatic ipmc_pkg::t_out_item advance_power_mode(ipmc_pkg::t_in_item ev);
        ipmc_pkg::t_mode     prior;
        ipmc_pkg::t_out_item res;
        prior = cur_mode;
        if (ev.cmd == ipmc_pkg::CMD_TICK) begin
            // Blank is serviced before sleep on the same tick.
            if (blank_counting) begin
                if (blank_left <= 32'd1) begin
                    blank_counting = 1'b0;
                    blank_left = '0;
                    if (cur_mode != ipmc_pkg::MODE_SLEEP) begin
                        cur_mode = ipmc_pkg::MODE_BLANK;
                    end
                end else begin
                    blank_left = blank_left - 32'd1;
                end
            end
            if (sleep_counting) begin
                if (sleep_left <= 32'd1) begin
                    if (cpu_gate && ev.cpu_load > busy_limit) begin
                        sleep_left = sleep_after;
                    end else begin
                        sleep_counting = 1'b0;
                        sleep_left = '0;
                        cur_mode = ipmc_pkg::MODE_SLEEP;
                    end
                end else begin
                    sleep_left = sleep_left - 32'd1;
                end
            end
        end else begin
            if (ev.cmd == ipmc_pkg::CMD_ACTIVITY) begin
                idle_flag = 1'b0;
            end else if (ev.cmd == ipmc_pkg::CMD_ALARM) begin
                idle_flag = 1'b1;
            end
            if (!idle_flag || ev.idle_blocked) begin
                cur_mode = ipmc_pkg::MODE_NORMAL;
                blank_on = 1'b0;
                blank_counting = 1'b0;
                blank_left = '0;
                sleep_on = 1'b0;
                sleep_counting = 1'b0;
                sleep_left = '0;
            end else begin
                if (cur_mode == ipmc_pkg::MODE_NORMAL) begin
                    cur_mode = ipmc_pkg::MODE_DIM;
                end
                if (!blank_on && blank_after != '0) begin
                    blank_on = 1'b1;
                    blank_counting = 1'b1;
                    blank_left = blank_after;
                end
                if (ev.susp_blocked) begin
                    sleep_on = 1'b0;
                    sleep_counting = 1'b0;
                    sleep_left = '0;
                end else if (ev.sess_idle && !sleep_on && sleep_after != '0) begin
                    sleep_on = 1'b1;
                    sleep_counting = 1'b1;
                    sleep_left = sleep_after;
                end
            end
        end
        res.power_mode = cur_mode;
        res.mode_changed = (cur_mode != prior);
        return res;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles with %0d words outstanding",
                     $time, cycles, expected_modes.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Result checker and predictor, both sampled on the accepting edge.
    always @(posedge clk) begin : scoreboard_p
        ipmc_pkg::t_out_item want;
        ipmc_pkg::t_out_item got;
        t_row_note           note;
        if (res_ch.valid && res_ch.ready) begin
            if (expected_modes.size() == 0) begin
                $display("%0t: result word with nothing expected: mode %0d changed %0d",
                         $time, res_ch.data.power_mode, res_ch.data.mode_changed);
                errors++;
            end else begin
                want = expected_modes.pop_front();
                if (res_ch.data.power_mode !== want.power_mode) begin
                    $display("%0t: power_mode expected %0d got %0d",
                             $time, want.power_mode, res_ch.data.power_mode);
                    errors++;
                end
                if (res_ch.data.mode_changed !== want.mode_changed) begin
                    $display("%0t: mode_changed expected %0d got %0d",
                             $time, want.mode_changed, res_ch.data.mode_changed);
                    errors++;
                end
                checked++;
                mode_hits[want.power_mode]++;
                if (want.mode_changed) begin
                    changes++;
                end
            end
        end
        if (evt_ch.valid && evt_ch.ready) begin
            got = advance_power_mode(evt_ch.data);
            note = row_notes.pop_front();
            expected_modes.push_back(note.typed ? note.want : got);
            accepted++;
        end
    end

    // Result side: random stall bursts, one long hold-off on request, none when calm.
    initial begin : result_side
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                hold = 80;
            end
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 12) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    task automatic offer_event(ipmc_pkg::t_in_item ev, bit typed, ipmc_pkg::t_out_item want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data <= ev;
        row_notes.push_back(t_row_note'{typed, want});
        do @(posedge clk); while (!evt_ch.ready);
    endtask

    // Lets every outstanding word come back, then waits for the pipeline to settle.
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_modes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(ipmc_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ipmc_pkg::REG_BLANK_TIMEOUT: blank_after = val;
            ipmc_pkg::REG_SLEEP_TIMEOUT: sleep_after = val;
            ipmc_pkg::REG_CHECK_CPU:     cpu_gate = val[0];
            ipmc_pkg::REG_CPU_LIMIT:     busy_limit = val[ipmc_pkg::LOAD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    initial begin : stimulus
        ipmc_pkg::t_in_item          ev;
        int                          pick;
        logic [31:0]                 blank_v;
        logic [31:0]                 sleep_v;
        logic                        gate_v;
        logic [ipmc_pkg::LOAD_W-1:0] limit_v;

        rst_n <= 1'b0;
        evt_ch.valid <= 1'b0;
        evt_ch.data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain_results();
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                ev = '{plan[i].cmd, plan[i].s_idle, plan[i].i_inh, plan[i].s_inh, plan[i].load};
                offer_event(ev, plan[i].typed, '{plan[i].mode, plan[i].chg});
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    blank_v = $urandom_range(1, 4);
                    sleep_v = $urandom_range(2, 8);
                    gate_v = 1'b0;
                    limit_v = 7'd5;
                end
                1: begin
                    // Blank never comes due here, so sleep is reached from dim.
                    blank_v = 32'hFFFF_FFFF;
                    sleep_v = $urandom_range(1, 3);
                    gate_v = 1'b1;
                    limit_v = ipmc_pkg::LOAD_W'($urandom_range(30, 90));
                end
                2: begin
                    blank_v = '0;
                    sleep_v = $urandom_range(1, 5);
                    gate_v = 1'b1;
                    limit_v = '0;
                end
                3: begin
                    blank_v = $urandom_range(1, 6);
                    sleep_v = '0;
                    gate_v = 1'b0;
                    limit_v = 7'd127;
                end
                default: begin
                    blank_v = 32'd3;
                    sleep_v = 32'd3;
                    gate_v = 1'b1;
                    limit_v = 7'd100;
                end
            endcase
            write_reg(ipmc_pkg::REG_BLANK_TIMEOUT, blank_v);
            write_reg(ipmc_pkg::REG_SLEEP_TIMEOUT, sleep_v);
            write_reg(ipmc_pkg::REG_CHECK_CPU, {31'd0, gate_v});
            write_reg(ipmc_pkg::REG_CPU_LIMIT, {25'd0, limit_v});
            if (phase == 1) begin
                stall_req = 1'b1;
            end
            if (phase == 4) begin
                calm = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                // Mostly ticks between idle alarms, so the timers get to run out.
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    ev.cmd = ipmc_pkg::CMD_TICK;
                end else if (pick < 70) begin
                    ev.cmd = ipmc_pkg::CMD_ALARM;
                end else if (pick < 85) begin
                    ev.cmd = ipmc_pkg::CMD_SESSION;
                end else begin
                    ev.cmd = ipmc_pkg::CMD_ACTIVITY;
                end
                ev.sess_idle = ($urandom_range(0, 9) < 7);
                ev.idle_blocked = ($urandom_range(0, 9) == 0);
                ev.susp_blocked = ($urandom_range(0, 7) == 0);
                ev.cpu_load = ipmc_pkg::LOAD_W'($urandom_range(0, 127));
                offer_event(ev, 1'b0, '0);
            end
        end
        drain_results();

        $display("Checked %0d result words for %0d events:", checked, accepted);
        $display("directed cases, then five register settings; modes seen:");
        $display("normal %0d, dim %0d, blank %0d, sleep %0d; %0d changes, %0d mismatches",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], changes, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
